/* rtl/etf_pkg.sv */
`default_nettype none

package etf_pkg;

   // Width of one multiplier digit handled by a product cell.
   localparam int DIGIT_BITS = 16;

   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRACTAL_MODE    = 3'd0,
      CSR_JULIA_C_REAL    = 3'd1,
      CSR_JULIA_C_IMAG    = 3'd2,
      CSR_PLANE_LEFT      = 3'd3,
      CSR_PLANE_TOP       = 3'd4,
      CSR_STEP_REAL       = 3'd5,
      CSR_STEP_IMAG       = 3'd6,
      CSR_ITERATION_LIMIT = 3'd7
   } csr_index_type;

   localparam logic MODE_MANDELBROT = 1'b0;
   localparam logic MODE_JULIA      = 1'b1;

   // Reset values of the Julia constant and plane registers, given in Q4.27.
   localparam longint Q27_JULIA_C_REAL = -64'sd112071803;
   localparam longint Q27_JULIA_C_IMAG = 64'sd31151935;
   localparam longint Q27_PLANE_LEFT   = -64'sd201326592;
   localparam longint Q27_PLANE_TOP    = 64'sd201326592;
   localparam longint Q27_STEP         = 64'sd393216;

   // Control that travels down a product chain next to the operands.
   typedef struct packed {
      logic valid;
      logic neg;
   } mul_tag_type;

   // Rescales a Q4.27 constant to value_bits-5 fraction bits, truncating
   // toward zero and saturating to the signed range.
   function automatic longint q27_rescale(input longint v, input int value_bits);
      longint r;
      longint vmax;
      int     frac;
      frac = value_bits - 5;
      vmax = (64'sd1 <<< (value_bits - 1)) - 64'sd1;
      if (frac >= 27) begin
         r = v <<< (frac - 27);
      end else if (v < 0) begin
         r = -((-v) >>> (27 - frac));
      end else begin
         r = v >>> (27 - frac);
      end
      if (r > vmax) begin
         r = vmax;
      end else if (r < -vmax - 64'sd1) begin
         r = -vmax - 64'sd1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/etf_if.sv */
`default_nettype none

// Pixel request channel.
interface etf_req_if #(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_column;
   logic [COORD_BITS-1:0] pixel_row;

   modport source (output valid, output pixel_column, output pixel_row, input ready);
   modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

// Escape count result channel.
interface etf_rsp_if #(
   parameter int COUNT_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] escape_count;
   logic                  in_set;

   modport source (output valid, output escape_count, output in_set, input ready);
   modport sink   (input valid, input escape_count, input in_set, output ready);
endinterface

`default_nettype wire

/* rtl/etf_mul_cell.sv */
`default_nettype none

// One cell of a product chain: adds the multiplicand times one digit of the
// multiplier into the running sum and hands everything to the next cell.
module etf_mul_cell #(
   parameter int A_BITS     = 32,
   parameter int B_BITS     = 32,
   parameter int ACC_BITS   = 64,
   parameter int CELL_INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  etf_pkg::mul_tag_type   tag_in,
   input  logic [A_BITS-1:0]      a_in,
   input  logic [B_BITS-1:0]      b_in,
   input  logic [ACC_BITS-1:0]    acc_in,
   output etf_pkg::mul_tag_type   tag_out,
   output logic [A_BITS-1:0]      a_out,
   output logic [B_BITS-1:0]      b_out,
   output logic [ACC_BITS-1:0]    acc_out
);
   import etf_pkg::*;

   localparam int OFFSET    = CELL_INDEX * DIGIT_BITS;
   localparam int PROD_BITS = A_BITS + DIGIT_BITS;
   localparam int WIDE_BITS = PROD_BITS + OFFSET + ACC_BITS;

   logic [DIGIT_BITS-1:0] digit;
   logic [PROD_BITS-1:0]  partial;
   logic [WIDE_BITS-1:0]  wide;
   mul_tag_type           tag_ff;
   logic [A_BITS-1:0]     a_ff;
   logic [B_BITS-1:0]     b_ff;
   logic [ACC_BITS-1:0]   acc_ff;
   logic [ACC_BITS-1:0]   acc_in_sum;

   assign digit      = b_in[OFFSET +: DIGIT_BITS];
   assign partial    = PROD_BITS'(a_in) * PROD_BITS'(digit);
   assign wide       = WIDE_BITS'(partial) << OFFSET;
   assign acc_in_sum = acc_in + wide[ACC_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in_sum;
   end

   assign tag_out = tag_ff;
   assign a_out   = a_ff;
   assign b_out   = b_ff;
   assign acc_out = acc_ff;

endmodule

`default_nettype wire

/* rtl/etf_mul_chain.sv */
`default_nettype none

// Fixed-point product of two magnitudes through a row of digit cells, then
// a shift toward zero and saturation with the requested sign.
module etf_mul_chain #(
   parameter int VALUE_BITS = 32,
   parameter int SHIFT      = 27
) (
   input  logic                          clock,
   input  logic                          reset,
   input  etf_pkg::mul_tag_type          tag_in,
   input  logic [VALUE_BITS-1:0]         mag_a,
   input  logic [VALUE_BITS-1:0]         mag_b,
   output logic                          result_valid,
   output logic signed [VALUE_BITS-1:0]  result
);
   import etf_pkg::*;

   localparam int NUM_DIGITS = (VALUE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int B_BITS     = NUM_DIGITS * DIGIT_BITS;
   localparam int ACC_BITS   = 2 * VALUE_BITS;

   mul_tag_type           tag_link [NUM_DIGITS+1];
   logic [VALUE_BITS-1:0] a_link   [NUM_DIGITS+1];
   logic [B_BITS-1:0]     b_link   [NUM_DIGITS+1];
   logic [ACC_BITS-1:0]   acc_link [NUM_DIGITS+1];

   logic [ACC_BITS-1:0]         product;
   logic                        overflow;
   logic [VALUE_BITS-2:0]       mag;
   logic signed [VALUE_BITS-1:0] result_in;
   logic signed [VALUE_BITS-1:0] result_ff;
   logic                        valid_ff;

   assign tag_link[0] = tag_in;
   assign a_link[0]   = mag_a;
   assign b_link[0]   = B_BITS'(mag_b);
   assign acc_link[0] = '0;

   for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
      etf_mul_cell #(
         .A_BITS     (VALUE_BITS),
         .B_BITS     (B_BITS),
         .ACC_BITS   (ACC_BITS),
         .CELL_INDEX (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tag_in  (tag_link[k]),
         .a_in    (a_link[k]),
         .b_in    (b_link[k]),
         .acc_in  (acc_link[k]),
         .tag_out (tag_link[k+1]),
         .a_out   (a_link[k+1]),
         .b_out   (b_link[k+1]),
         .acc_out (acc_link[k+1])
      );
   end

   // Any bit at or above the sign position of the shifted value saturates.
   assign product  = acc_link[NUM_DIGITS];
   assign overflow = |product[ACC_BITS-1:SHIFT+VALUE_BITS-1];
   assign mag      = product[SHIFT+VALUE_BITS-2:SHIFT];

   always_comb begin
      if (overflow) begin
         result_in = tag_link[NUM_DIGITS].neg ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                              : {1'b0, {(VALUE_BITS-1){1'b1}}};
      end else if (tag_link[NUM_DIGITS].neg) begin
         result_in = -$signed({1'b0, mag});
      end else begin
         result_in = $signed({1'b0, mag});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tag_link[NUM_DIGITS].valid;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result_valid = valid_ff;
   assign result       = result_ff;

endmodule

`default_nettype wire

/* rtl/escape_time_fractal_iteration.sv */
`default_nettype none

// Escape-time iteration engine for Mandelbrot and Julia images.
//
// A pixel word (column, row) arrives on req; the block maps it onto the
// complex plane, iterates z = z*z + c and returns one word on rsp holding the
// number of iterations done and a flag set when the iteration limit was
// reached. The user must write the plane, step sizes, mode, Julia constant
// and limit on the csr write port only while idle; the block does not enforce it.
//
// Structure: the pixel mapping registers the column and row products, then
// the starting point. Each iteration passes the operand registers, the
// NUM_DIGITS product cells of a chain, where NUM_DIGITS is VALUE_BITS/16
// rounded up, the chain's result register and the escape test register.
// A new pixel is taken only while idle, so one pixel is worked on at a time.
//
// Reset loads the default view and Julia constant and empties the engine and
// the output register. A finished word sits in the output register until rsp
// takes it; a new pixel is accepted meanwhile, and a second finished word
// waits in the engine while the output register is still full.
module escape_time_fractal_iteration #(
   parameter int COORD_BITS = 12,
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   etf_req_if.sink                 req,
   etf_rsp_if.source               rsp,
   input  logic                    csr_write_enable,
   input  etf_pkg::csr_index_type  csr_index,
   input  logic [VALUE_BITS-1:0]   csr_write_data
);
   import etf_pkg::*;

   localparam int FRAC_BITS = VALUE_BITS - 5;
   localparam int MAP_BITS  = COORD_BITS + VALUE_BITS - 1;
   localparam int WIDE_BITS = VALUE_BITS + 2;

   localparam logic signed [VALUE_BITS-1:0] RESET_JULIA_C_REAL =
      VALUE_BITS'(q27_rescale(Q27_JULIA_C_REAL, VALUE_BITS));
   localparam logic signed [VALUE_BITS-1:0] RESET_JULIA_C_IMAG =
      VALUE_BITS'(q27_rescale(Q27_JULIA_C_IMAG, VALUE_BITS));
   localparam logic signed [VALUE_BITS-1:0] RESET_PLANE_LEFT =
      VALUE_BITS'(q27_rescale(Q27_PLANE_LEFT, VALUE_BITS));
   localparam logic signed [VALUE_BITS-1:0] RESET_PLANE_TOP =
      VALUE_BITS'(q27_rescale(Q27_PLANE_TOP, VALUE_BITS));
   localparam logic [VALUE_BITS-2:0] RESET_STEP =
      (VALUE_BITS-1)'(q27_rescale(Q27_STEP, VALUE_BITS));
   localparam logic [COUNT_BITS-1:0] RESET_LIMIT = COUNT_BITS'(255);

   localparam logic signed [WIDE_BITS-1:0] WIDE_MAX = {3'b000, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [WIDE_BITS-1:0] WIDE_MIN = {3'b111, {(VALUE_BITS-1){1'b0}}};
   localparam logic [MAP_BITS-1:0]         MAP_CAP  = MAP_BITS'(1) << VALUE_BITS;
   localparam logic [VALUE_BITS:0]         BOUND    = (VALUE_BITS+1)'(1) << (VALUE_BITS-3);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MAP    = 6'b000010,
      ST_CHECK  = 6'b000100,
      ST_WAIT   = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   function automatic logic signed [WIDE_BITS-1:0] widen(input logic signed [VALUE_BITS-1:0] v);
      return {{2{v[VALUE_BITS-1]}}, v};
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] clamp_value(
      input logic signed [WIDE_BITS-1:0] v
   );
      logic signed [VALUE_BITS-1:0] r;
      if (v > WIDE_MAX) begin
         r = WIDE_MAX[VALUE_BITS-1:0];
      end else if (v < WIDE_MIN) begin
         r = WIDE_MIN[VALUE_BITS-1:0];
      end else begin
         r = v[VALUE_BITS-1:0];
      end
      return r;
   endfunction

   // Configuration registers.
   logic                         fractal_mode_ff;
   logic signed [VALUE_BITS-1:0] julia_c_real_ff;
   logic signed [VALUE_BITS-1:0] julia_c_imag_ff;
   logic signed [VALUE_BITS-1:0] plane_left_ff;
   logic signed [VALUE_BITS-1:0] plane_top_ff;
   logic [VALUE_BITS-2:0]        step_real_ff;
   logic [VALUE_BITS-2:0]        step_imag_ff;
   logic [COUNT_BITS-1:0]        iteration_limit_ff;

   // Sequencer and iteration state.
   state_type                    state_ff, state_in;
   logic [MAP_BITS-1:0]          prod_re_ff, prod_im_ff;
   logic signed [VALUE_BITS-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [VALUE_BITS-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;

   // Operand registers in front of the product chains.
   logic                         op_valid_ff, op_valid_in;
   logic [VALUE_BITS-1:0]        mag_r_ff, mag_i_ff;
   logic                         sign_r_ff, sign_i_ff;
   mul_tag_type                  square_tag, cross_tag;

   logic                         sr_valid, si_valid, cross_valid;
   logic signed [VALUE_BITS-1:0] sr, si, cross_term;

   // Escape test and partial update.
   logic                         escape_ff;
   logic signed [VALUE_BITS-1:0] diff_ff, zi_next_ff;
   logic [VALUE_BITS:0]          radius;

   // Pixel mapping.
   logic [VALUE_BITS:0]          cap_re, cap_im;
   logic signed [WIDE_BITS-1:0]  re_wide, im_wide;
   logic signed [VALUE_BITS-1:0] point_re, point_im;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]        rsp_count_ff;
   logic                         rsp_in_set_ff;
   logic                         out_free;
   logic                         req_accept;
   logic                         load_output;

   assign req.ready  = (state_ff == ST_IDLE);
   assign req_accept = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;

   // Configuration writes; the decode covers every index.
   always_ff @(posedge clock) begin
      if (reset) begin
         fractal_mode_ff    <= MODE_JULIA;
         julia_c_real_ff    <= RESET_JULIA_C_REAL;
         julia_c_imag_ff    <= RESET_JULIA_C_IMAG;
         plane_left_ff      <= RESET_PLANE_LEFT;
         plane_top_ff       <= RESET_PLANE_TOP;
         step_real_ff       <= RESET_STEP;
         step_imag_ff       <= RESET_STEP;
         iteration_limit_ff <= RESET_LIMIT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRACTAL_MODE:    fractal_mode_ff    <= csr_write_data[0];
            CSR_JULIA_C_REAL:    julia_c_real_ff    <= csr_write_data;
            CSR_JULIA_C_IMAG:    julia_c_imag_ff    <= csr_write_data;
            CSR_PLANE_LEFT:      plane_left_ff      <= csr_write_data;
            CSR_PLANE_TOP:       plane_top_ff       <= csr_write_data;
            CSR_STEP_REAL:       step_real_ff       <= csr_write_data[VALUE_BITS-2:0];
            CSR_STEP_IMAG:       step_imag_ff       <= csr_write_data[VALUE_BITS-2:0];
            CSR_ITERATION_LIMIT: iteration_limit_ff <= csr_write_data[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // The column and row products are formed as the pixel word is taken.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         prod_re_ff <= MAP_BITS'(req.pixel_column) * MAP_BITS'(step_real_ff);
         prod_im_ff <= MAP_BITS'(req.pixel_row) * MAP_BITS'(step_imag_ff);
      end
   end

   // Offsets beyond the width of the plane are capped, then the point
   // saturates to the value range.
   assign cap_re   = (prod_re_ff > MAP_CAP) ? MAP_CAP[VALUE_BITS:0] : prod_re_ff[VALUE_BITS:0];
   assign cap_im   = (prod_im_ff > MAP_CAP) ? MAP_CAP[VALUE_BITS:0] : prod_im_ff[VALUE_BITS:0];
   assign re_wide  = widen(plane_left_ff) + $signed({1'b0, cap_re});
   assign im_wide  = widen(plane_top_ff) - $signed({1'b0, cap_im});
   assign point_re = clamp_value(re_wide);
   assign point_im = clamp_value(im_wide);

   // Squares of nonnegative saturated values: no overflow in one extra bit.
   assign radius = {1'b0, sr[VALUE_BITS-1:0]} + {1'b0, si[VALUE_BITS-1:0]};

   assign load_output = (state_ff == ST_FINISH) && out_free;

   always_comb begin
      state_in    = state_ff;
      zr_in       = zr_ff;
      zi_in       = zi_ff;
      cr_in       = cr_ff;
      ci_in       = ci_ff;
      count_in    = count_ff;
      op_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            count_in = '0;
            if (fractal_mode_ff == MODE_MANDELBROT) begin
               cr_in = point_re;
               ci_in = point_im;
               zr_in = '0;
               zi_in = '0;
            end else begin
               zr_in = point_re;
               zi_in = point_im;
               cr_in = julia_c_real_ff;
               ci_in = julia_c_imag_ff;
            end
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (count_ff < iteration_limit_ff) begin
               op_valid_in = 1'b1;
               state_in    = ST_WAIT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WAIT: begin
            if (sr_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (escape_ff) begin
               state_in = ST_FINISH;
            end else begin
               zr_in    = clamp_value(widen(diff_ff) + widen(cr_ff));
               zi_in    = zi_next_ff;
               count_in = count_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         op_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         op_valid_ff <= op_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      count_ff <= count_in;
   end

   // The chains work on magnitudes; the sign of the cross term rides along.
   always_ff @(posedge clock) begin
      if (op_valid_in) begin
         mag_r_ff  <= zr_ff[VALUE_BITS-1] ? VALUE_BITS'(-zr_ff) : VALUE_BITS'(zr_ff);
         mag_i_ff  <= zi_ff[VALUE_BITS-1] ? VALUE_BITS'(-zi_ff) : VALUE_BITS'(zi_ff);
         sign_r_ff <= zr_ff[VALUE_BITS-1];
         sign_i_ff <= zi_ff[VALUE_BITS-1];
      end
   end

   assign square_tag = '{valid: op_valid_ff, neg: 1'b0};
   assign cross_tag  = '{valid: op_valid_ff, neg: sign_r_ff ^ sign_i_ff};

   etf_mul_chain #(
      .VALUE_BITS (VALUE_BITS),
      .SHIFT      (FRAC_BITS)
   ) u_square_real (
      .clock        (clock),
      .reset        (reset),
      .tag_in       (square_tag),
      .mag_a        (mag_r_ff),
      .mag_b        (mag_r_ff),
      .result_valid (sr_valid),
      .result       (sr)
   );

   etf_mul_chain #(
      .VALUE_BITS (VALUE_BITS),
      .SHIFT      (FRAC_BITS)
   ) u_square_imag (
      .clock        (clock),
      .reset        (reset),
      .tag_in       (square_tag),
      .mag_a        (mag_i_ff),
      .mag_b        (mag_i_ff),
      .result_valid (si_valid),
      .result       (si)
   );

   // Twice the cross product: one fraction bit less of shift.
   etf_mul_chain #(
      .VALUE_BITS (VALUE_BITS),
      .SHIFT      (FRAC_BITS - 1)
   ) u_cross (
      .clock        (clock),
      .reset        (reset),
      .tag_in       (cross_tag),
      .mag_a        (mag_r_ff),
      .mag_b        (mag_i_ff),
      .result_valid (cross_valid),
      .result       (cross_term)
   );

   always_ff @(posedge clock) begin
      if (sr_valid) begin
         escape_ff  <= (radius > BOUND);
         diff_ff    <= clamp_value(widen(sr) - widen(si));
         zi_next_ff <= clamp_value(widen(cross_term) + widen(ci_ff));
      end
   end

   // Output register: holds one finished word while the engine goes on.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (load_output) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_output) begin
         rsp_count_ff  <= count_ff;
         rsp_in_set_ff <= (count_ff == iteration_limit_ff);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.escape_count = rsp_count_ff;
   assign rsp.in_set       = rsp_in_set_ff;

   // Product results only come back while the sequencer waits for them.
   assert property (@(posedge clock) disable iff (reset)
      sr_valid |-> (state_ff == ST_WAIT))
      else $error("product result outside the wait state");

   // The three chains run in lockstep.
   assert property (@(posedge clock) disable iff (reset)
      (sr_valid == si_valid) && (sr_valid == cross_valid))
      else $error("product chains out of step");

   // A completed iteration advances the count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) && !escape_ff |=>
         (count_ff == COUNT_BITS'($past(count_ff) + 1'b1)))
      else $error("iteration count did not advance by one");

   // A result word is only produced by the finish state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result word raised outside the finish state");

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

// Self-checking bench for the escape-time fractal engine.
//
// Pixel words are queued by the stimulus process and handed to the block by a
// clocked driver that works in bursts with random gaps. Each word the block
// accepts is run through a local model of the iteration, and the outcome is
// queued. A clocked monitor takes result words under its own stall pattern and
// compares each one with the oldest queued outcome. Register changes happen
// only with the engine drained.
module tb;
   import etf_pkg::*;

   localparam int     COORD_BITS   = 12;
   localparam int     VALUE_BITS   = 32;
   localparam int     COUNT_BITS   = 12;
   localparam int     FRAC_BITS    = VALUE_BITS - 5;
   localparam longint VALUE_MAX    = 64'sd2147483647;
   localparam longint VALUE_MIN    = -64'sd2147483648;
   localparam longint ESCAPE_BOUND = 64'sd4 <<< FRAC_BITS;
   localparam longint MAP_CAP      = 64'sd1 <<< VALUE_BITS;
   localparam real    Q_ONE        = 134217728.0;
   localparam int     RANDOM_ITEMS = 1700;
   localparam int     CYCLE_LIMIT  = 4_000_000;

   typedef struct packed {
      logic [COORD_BITS-1:0] column;
      logic [COORD_BITS-1:0] row;
   } pixel_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] column;
      logic [COORD_BITS-1:0] row;
      logic [COUNT_BITS-1:0] escape_count;
      logic                  in_set;
   } pixel_outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   csr_index_type         csr_index;
   logic [VALUE_BITS-1:0] csr_write_data;

   etf_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   etf_rsp_if #(.COUNT_BITS(COUNT_BITS)) rsp_bus ();

   escape_time_fractal_iteration #(
      .COORD_BITS(COORD_BITS),
      .VALUE_BITS(VALUE_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Local copy of the register file, masked the way the block keeps it.
   logic                  fractal_mode_q;
   longint                julia_re_q;
   longint                julia_im_q;
   longint                plane_left_q;
   longint                plane_top_q;
   logic [VALUE_BITS-2:0] step_real_q;
   logic [VALUE_BITS-2:0] step_imag_q;
   logic [COUNT_BITS-1:0] iteration_limit_q;

   pixel_type         pixel_backlog[$];
   pixel_outcome_type pending_escapes[$];

   int        cycle_count;
   int        mismatch_count;
   pixel_type next_pixel;
   int        burst_left;
   int        gap_left;
   bit        drain_hold;
   bit        drained_once;
   int        ready_left;
   int        stall_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_value(input longint v);
      if (v > VALUE_MAX) begin
         return VALUE_MAX;
      end
      if (v < VALUE_MIN) begin
         return VALUE_MIN;
      end
      return v;
   endfunction

   // Exact product of two values, shifted right with truncation of the
   // magnitude, then saturated. Operands never exceed 2^31 in magnitude, so the
   // full product fits in 64 bits.
   function automatic longint scaled_product(input longint a, input longint b,
                                             input int sh_amt);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] mag;
      logic        neg;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? 64'(-a) : 64'(a);
      mb  = (b < 0) ? 64'(-b) : 64'(b);
      mag = (ma * mb) >> sh_amt;
      if (mag > 64'(VALUE_MAX)) begin
         return neg ? VALUE_MIN : VALUE_MAX;
      end
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   // One axis of the pixel mapping. The offset is capped at 2^VALUE_BITS
   // before it is applied, and the sum saturates.
   function automatic longint map_to_plane(input longint base,
                                           input logic [COORD_BITS-1:0] coord,
                                           input logic [VALUE_BITS-2:0] step,
                                           input logic down);
      longint offset;
      offset = longint'(coord) * longint'(step);
      if (offset > MAP_CAP) begin
         offset = MAP_CAP;
      end
      return clamp_value(down ? base - offset : base + offset);
   endfunction

   // Full escape-time run for one pixel under the current register copy.
   function automatic pixel_outcome_type iterate_pixel(input logic [COORD_BITS-1:0] column,
                                                       input logic [COORD_BITS-1:0] row);
      longint            pre;
      longint            pim;
      longint            zr;
      longint            zi;
      longint            cr;
      longint            ci;
      longint            sr;
      longint            si;
      longint            cross_term;
      int unsigned       count;
      pixel_outcome_type outcome;
      pre = map_to_plane(plane_left_q, column, step_real_q, 1'b0);
      pim = map_to_plane(plane_top_q, row, step_imag_q, 1'b1);
      if (fractal_mode_q == MODE_MANDELBROT) begin
         cr = pre;
         ci = pim;
         zr = 0;
         zi = 0;
      end else begin
         zr = pre;
         zi = pim;
         cr = julia_re_q;
         ci = julia_im_q;
      end
      count = 0;
      while (count < iteration_limit_q) begin
         sr = scaled_product(zr, zr, FRAC_BITS);
         si = scaled_product(zi, zi, FRAC_BITS);
         // Both squares are already saturated, so a huge z always escapes here.
         if (sr + si > ESCAPE_BOUND) begin
            break;
         end
         cross_term = scaled_product(zr, zi, FRAC_BITS - 1);
         zr         = clamp_value(clamp_value(sr - si) + cr);
         zi         = clamp_value(cross_term + ci);
         count++;
      end
      outcome.column       = column;
      outcome.row          = row;
      outcome.escape_count = count[COUNT_BITS-1:0];
      outcome.in_set       = (count == iteration_limit_q);
      return outcome;
   endfunction

   function automatic pixel_type pixel_at(input int column, input int row);
      pixel_type p;
      p.column = column[COORD_BITS-1:0];
      p.row    = row[COORD_BITS-1:0];
      return p;
   endfunction

   task automatic log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
   endtask

   // Waits until no word is queued, offered or owed. The check runs on the
   // falling edge so that it sees the settled result of every rising edge.
   // It then waits on so that the engine comes fully to rest.
   task automatic settle();
      do begin
         @(negedge clock);
      end while (pixel_backlog.size() != 0 || req_bus.valid || pending_escapes.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [VALUE_BITS-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_FRACTAL_MODE: begin
            fractal_mode_q = data[0];
         end
         CSR_JULIA_C_REAL: begin
            julia_re_q = longint'(signed'(data));
         end
         CSR_JULIA_C_IMAG: begin
            julia_im_q = longint'(signed'(data));
         end
         CSR_PLANE_LEFT: begin
            plane_left_q = longint'(signed'(data));
         end
         CSR_PLANE_TOP: begin
            plane_top_q = longint'(signed'(data));
         end
         CSR_STEP_REAL: begin
            step_real_q = data[VALUE_BITS-2:0];
         end
         CSR_STEP_IMAG: begin
            step_imag_q = data[VALUE_BITS-2:0];
         end
         CSR_ITERATION_LIMIT: begin
            iteration_limit_q = data[COUNT_BITS-1:0];
         end
         default: begin
         end
      endcase
   endtask

   // Drains the engine, then rewrites every register in index order.
   task automatic load_view(input logic [VALUE_BITS-1:0] mode_word,
                            input logic [VALUE_BITS-1:0] c_re,
                            input logic [VALUE_BITS-1:0] c_im,
                            input logic [VALUE_BITS-1:0] left,
                            input logic [VALUE_BITS-1:0] top,
                            input logic [VALUE_BITS-1:0] step_re,
                            input logic [VALUE_BITS-1:0] step_im,
                            input logic [VALUE_BITS-1:0] limit_word);
      settle();
      write_register(CSR_FRACTAL_MODE, mode_word);
      write_register(CSR_JULIA_C_REAL, c_re);
      write_register(CSR_JULIA_C_IMAG, c_im);
      write_register(CSR_PLANE_LEFT, left);
      write_register(CSR_PLANE_TOP, top);
      write_register(CSR_STEP_REAL, step_re);
      write_register(CSR_STEP_IMAG, step_im);
      write_register(CSR_ITERATION_LIMIT, limit_word);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Pixel driver. A word that is offered stays on the bus until it is taken.
   // Whenever the slot is free, the driver either sits out a gap, holds off
   // until every owed result has come back, or offers the next queued pixel.
   // The outcome of an accepted word is computed from the bus values as they
   // were at the accepting edge.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.pixel_column <= '0;
         req_bus.pixel_row    <= '0;
         burst_left   = 0;
         gap_left     = 0;
         drain_hold   = 1'b0;
         drained_once = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_escapes.push_back(iterate_pixel(req_bus.pixel_column, req_bus.pixel_row));
         end
         if (!req_bus.valid || req_bus.ready) begin
            // An accepted word was pushed above, so an empty queue here really
            // means the engine has handed back everything.
            if (drain_hold && pending_escapes.size() == 0) begin
               drain_hold = 1'b0;
            end
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (drain_hold || pixel_backlog.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else begin
               next_pixel = pixel_backlog.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.pixel_column <= next_pixel.column;
               req_bus.pixel_row    <= next_pixel.row;
               if (burst_left > 0) begin
                  burst_left--;
               end
               if (burst_left == 0) begin
                  // End of a burst: pick the next burst, a gap that is sometimes
                  // absent, and now and then a full hold-off until drained.
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                  if (!drained_once || $urandom_range(0, 7) == 0) begin
                     drain_hold   = 1'b1;
                     drained_once = 1'b1;
                  end
               end
            end
         end
      end
   end

   // Result monitor. Each accepted word is matched against the oldest owed
   // outcome. The ready pattern alternates runs of readiness with stalls that
   // are sometimes absent, sometimes short and sometimes long.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_left = 0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_escapes.size() == 0) begin
               log_mismatch($sformatf("unexpected word: count %0d in_set %0b",
                                      rsp_bus.escape_count, rsp_bus.in_set));
            end else if (rsp_bus.escape_count !== pending_escapes[0].escape_count ||
                         rsp_bus.in_set !== pending_escapes[0].in_set) begin
               log_mismatch($sformatf(
                  "pixel (%0d,%0d): expected count %0d in_set %0b, got count %0d in_set %0b",
                  pending_escapes[0].column, pending_escapes[0].row,
                  pending_escapes[0].escape_count, pending_escapes[0].in_set,
                  rsp_bus.escape_count, rsp_bus.in_set));
               void'(pending_escapes.pop_front());
            end else begin
               void'(pending_escapes.pop_front());
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (ready_left > 0) begin
               ready_left--;
            end else begin
               ready_left = $urandom_range(0, 40);
               stall_left = ($urandom_range(0, 2) == 0) ? 0 :
                            $urandom_range(1, ($urandom_range(0, 1) == 0) ? 3 : 30);
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                    random_sent;
      int                    items;
      int                    width;
      int                    pick;
      logic                  mode_bit;
      logic [COUNT_BITS-1:0] limit_value;
      logic [VALUE_BITS-1:0] c_re;
      logic [VALUE_BITS-1:0] c_im;
      logic [VALUE_BITS-1:0] left;
      logic [VALUE_BITS-1:0] top;
      logic [VALUE_BITS-1:0] step_re;
      logic [VALUE_BITS-1:0] step_im;
      logic [VALUE_BITS-1:0] noise;
      real                   span;
      real                   center_re;
      real                   center_im;
      real                   c_re_r;
      real                   c_im_r;

      cycle_count    = 0;
      mismatch_count = 0;
      reset          = 1'b1;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_FRACTAL_MODE;
      csr_write_data       = '0;
      req_bus.valid        = 1'b0;
      req_bus.pixel_column = '0;
      req_bus.pixel_row    = '0;
      rsp_bus.ready        = 1'b0;

      // Register copy at its reset contents: the default Julia view.
      fractal_mode_q    = MODE_JULIA;
      julia_re_q        = Q27_JULIA_C_REAL;
      julia_im_q        = Q27_JULIA_C_IMAG;
      plane_left_q      = Q27_PLANE_LEFT;
      plane_top_q       = Q27_PLANE_TOP;
      step_real_q       = (VALUE_BITS-1)'(Q27_STEP);
      step_imag_q       = (VALUE_BITS-1)'(Q27_STEP);
      iteration_limit_q = COUNT_BITS'(255);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset view as it comes up: corners, the middle and alternating bits.
      pixel_backlog.push_back(pixel_at(0, 0));
      pixel_backlog.push_back(pixel_at(4095, 4095));
      pixel_backlog.push_back(pixel_at(4095, 0));
      pixel_backlog.push_back(pixel_at(0, 4095));
      pixel_backlog.push_back(pixel_at(512, 512));
      pixel_backlog.push_back(pixel_at('hAAA, 'h555));
      pixel_backlog.push_back(pixel_at('h555, 'hAAA));

      // Mandelbrot over the default plane at the largest limit. The middle
      // pixel lands on c = 0 and never escapes. Upper bits of the mode and
      // limit words are set and must be dropped.
      load_view(32'hFFFF_FFFE, VALUE_BITS'(Q27_JULIA_C_REAL), VALUE_BITS'(Q27_JULIA_C_IMAG),
                VALUE_BITS'(Q27_PLANE_LEFT), VALUE_BITS'(Q27_PLANE_TOP),
                VALUE_BITS'(Q27_STEP), VALUE_BITS'(Q27_STEP), 32'hFFFF_FFFF);
      pixel_backlog.push_back(pixel_at(512, 512));
      pixel_backlog.push_back(pixel_at(0, 0));
      pixel_backlog.push_back(pixel_at(100, 700));

      // Pixel mapping saturation: the plane starts at the extremes and the
      // steps are the largest possible, so the offset also hits its cap.
      load_view(32'h0000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4095);
      pixel_backlog.push_back(pixel_at(4095, 4095));
      pixel_backlog.push_back(pixel_at(0, 0));
      pixel_backlog.push_back(pixel_at(1, 1));
      pixel_backlog.push_back(pixel_at(2, 2));

      // Julia with the largest constant: huge starting points escape at once,
      // a tiny one takes a single step.
      load_view(32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd7);
      pixel_backlog.push_back(pixel_at(0, 0));
      pixel_backlog.push_back(pixel_at(1, 1));
      pixel_backlog.push_back(pixel_at(4095, 4095));

      // Smallest constant with z = i everywhere: the real sum saturates
      // downward, and a limit of one is reached.
      load_view(32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0800_0000,
                32'h0, 32'h0, 32'd1);
      pixel_backlog.push_back(pixel_at(4095, 0));
      pixel_backlog.push_back(pixel_at('h800, 1));

      // Zero limit: no iteration at all, and the word reports in-set.
      load_view(32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0800_0000,
                32'h0, 32'h0, 32'hFFFF_F000);
      pixel_backlog.push_back(pixel_at(0, 4095));
      pixel_backlog.push_back(pixel_at(4095, 4095));

      // Random views. Most are sensible windows onto the interesting part of
      // the plane with pixels inside the image, so that orbits run long
      // enough to matter; the rest are raw register noise.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         noise    = $urandom();
         mode_bit = noise[0];
         width    = 1 << $urandom_range(3, 12);
         case ($urandom_range(0, 5))
            0: begin c_re_r = -0.8;   c_im_r = 0.156;   end
            1: begin c_re_r = -0.4;   c_im_r = 0.6;     end
            2: begin c_re_r = 0.285;  c_im_r = 0.01;    end
            3: begin c_re_r = -0.835; c_im_r = -0.2321; end
            4: begin c_re_r = -0.75;  c_im_r = 0.11;    end
            default: begin c_re_r = 0.35; c_im_r = 0.35; end
         endcase
         if ($urandom_range(0, 4) == 0) begin
            c_re    = $urandom();
            c_im    = $urandom();
            left    = $urandom();
            top     = $urandom();
            step_re = $urandom();
            step_im = $urandom();
         end else begin
            span = 3.2 / (1 << $urandom_range(0, 6));
            if (mode_bit == MODE_MANDELBROT) begin
               center_re = -2.0 + 2.6 * $urandom_range(0, 1000) / 1000.0;
               center_im = -1.2 + 2.4 * $urandom_range(0, 1000) / 1000.0;
            end else begin
               center_re = -0.6 + 1.2 * $urandom_range(0, 1000) / 1000.0;
               center_im = -0.6 + 1.2 * $urandom_range(0, 1000) / 1000.0;
            end
            c_re    = $rtoi(c_re_r * Q_ONE);
            c_im    = $rtoi(c_im_r * Q_ONE);
            left    = $rtoi((center_re - span / 2.0) * Q_ONE);
            top     = $rtoi((center_im + span / 2.0) * Q_ONE);
            step_re = $rtoi(span * Q_ONE / width);
            step_im = $rtoi(span * Q_ONE / width);
            step_re[31] = noise[1];
            step_im[31] = noise[2];
         end
         // Limits stay small for the bulk; the long limits get few pixels.
         pick = $urandom_range(0, 19);
         case (pick)
            0: begin limit_value = '0;                     items = $urandom_range(10, 30); end
            1: begin limit_value = COUNT_BITS'(1);          items = $urandom_range(10, 30); end
            2: begin limit_value = COUNT_BITS'(255);        items = $urandom_range(5, 20);  end
            3: begin limit_value = '1;                     items = $urandom_range(1, 2);   end
            default: begin
               limit_value = COUNT_BITS'($urandom_range(2, 48));
               items       = $urandom_range(40, 140);
            end
         endcase
         load_view({noise[31:1], mode_bit}, c_re, c_im, left, top, step_re, step_im,
                   {noise[31:COUNT_BITS], limit_value});
         repeat (items) begin
            if ($urandom_range(0, 9) == 0) begin
               pixel_backlog.push_back(pixel_at($urandom_range(0, 4095), $urandom_range(0, 4095)));
            end else begin
               pixel_backlog.push_back(pixel_at($urandom_range(0, width - 1),
                                                $urandom_range(0, width - 1)));
            end
         end
         random_sent += items;
      end

      // Everything owed must come back, and nothing more may follow.
      settle();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* escape_time_fractal_iteration.f */
rtl/etf_pkg.sv
rtl/etf_if.sv
rtl/etf_mul_cell.sv
rtl/etf_mul_chain.sv
rtl/escape_time_fractal_iteration.sv
tb/tb.sv
